/* src/mlrt_pkg.sv */
// Shared types, codes and defaults of the radix index table.
package mlrt_pkg;

    // Parameter defaults.
    localparam int DEF_INDEX_WIDTH     = 32;
    localparam int DEF_MAX_STRIDE_BITS = 8;
    localparam int DEF_POOL_NODES      = 64;
    localparam int DEF_VALUE_WIDTH     = 32;
    localparam int DEF_MAX_LEVELS      = 4;

    // Levels that the hardware can walk, and fixed port widths.
    localparam int HW_LEVELS = 4;
    localparam int LVL_W     = 2;
    localparam int KEY_W     = 32;
    localparam int DATA_W    = 32;
    localparam int APB_AW    = 5;

    // Operation codes.
    localparam logic [2:0] FN_SET   = 3'd0;
    localparam logic [2:0] FN_GET   = 3'd1;
    localparam logic [2:0] FN_DEL   = 3'd2;
    localparam logic [2:0] FN_NEXT  = 3'd3;
    localparam logic [2:0] FN_CLEAR = 3'd4;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_POOL = 2'd1;
    localparam logic [1:0] ST_CFG  = 2'd2;

    // Register indexes.
    localparam logic [2:0] RG_INDEX_BITS  = 3'd0;
    localparam logic [2:0] RG_LEVEL_COUNT = 3'd1;
    localparam logic [2:0] RG_LEVEL0_BITS = 3'd2;
    localparam logic [2:0] RG_LEVEL1_BITS = 3'd3;
    localparam logic [2:0] RG_LEVEL2_BITS = 3'd4;
    localparam logic [2:0] RG_LEVEL3_BITS = 3'd5;

    // Register reset values.
    localparam logic [5:0] RST_INDEX_BITS  = 6'd24;
    localparam logic [2:0] RST_LEVEL_COUNT = 3'd3;
    localparam logic [HW_LEVELS-1:0][3:0] RST_LEVEL_BITS = {4'd0, 4'd8, 4'd8, 4'd8};

    // Decoded configuration handed to the sequencer.
    typedef struct packed {
        logic                           ok;
        logic [LVL_W-1:0]               last;
        logic [5:0]                     index_bits;
        logic [HW_LEVELS-1:0][3:0]      stride;
        logic [HW_LEVELS-1:0][5:0]      shift;
    } t_cfg;

    // Mask of the low nbits bits of an index.
    function automatic logic [KEY_W-1:0] low_mask(input logic [5:0] nbits);
        logic [KEY_W-1:0] m;
        for (int i = 0; i < KEY_W; i++) begin
            m[i] = (i < int'(nbits));
        end
        return m;
    endfunction

endpackage

/* src/mlrt_ram.sv */
// Simple dual-port RAM: one write port, one registered read port.
module mlrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write first in program order; a read of the same entry sees old data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/mlrt_cfg.sv */
// Configuration registers, APB access and stride decode.
module mlrt_cfg #(
    parameter int INDEX_WIDTH     = mlrt_pkg::DEF_INDEX_WIDTH,
    parameter int MAX_STRIDE_BITS = mlrt_pkg::DEF_MAX_STRIDE_BITS,
    parameter int MAX_LEVELS      = mlrt_pkg::DEF_MAX_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlrt_pkg::APB_AW-1:0] paddr,
    input  logic [mlrt_pkg::DATA_W-1:0] pwdata,
    output logic [mlrt_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output mlrt_pkg::t_cfg              o_cfg,
    output logic                        o_wr
);

    logic [5:0]                               r_index_bits;
    logic [2:0]                               r_level_count;
    logic [mlrt_pkg::HW_LEVELS-1:0][3:0]      r_level_bits;
    logic [2:0]                               reg_sel;
    logic                                     wr_beat;
    logic                                     sel_ok;

    assign reg_sel = paddr[4:2];
    assign wr_beat = psel && penable && pwrite;
    assign sel_ok  = (reg_sel <= mlrt_pkg::RG_LEVEL3_BITS);
    assign pready  = 1'b1;
    assign o_wr    = wr_beat && sel_ok;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= mlrt_pkg::RST_INDEX_BITS;
            r_level_count <= mlrt_pkg::RST_LEVEL_COUNT;
            r_level_bits  <= mlrt_pkg::RST_LEVEL_BITS;
        end else if (wr_beat) begin
            case (reg_sel)
                mlrt_pkg::RG_INDEX_BITS:  r_index_bits    <= pwdata[5:0];
                mlrt_pkg::RG_LEVEL_COUNT: r_level_count   <= pwdata[2:0];
                mlrt_pkg::RG_LEVEL0_BITS: r_level_bits[0] <= pwdata[3:0];
                mlrt_pkg::RG_LEVEL1_BITS: r_level_bits[1] <= pwdata[3:0];
                mlrt_pkg::RG_LEVEL2_BITS: r_level_bits[2] <= pwdata[3:0];
                mlrt_pkg::RG_LEVEL3_BITS: r_level_bits[3] <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        case (reg_sel)
            mlrt_pkg::RG_INDEX_BITS:  prdata = mlrt_pkg::DATA_W'(r_index_bits);
            mlrt_pkg::RG_LEVEL_COUNT: prdata = mlrt_pkg::DATA_W'(r_level_count);
            mlrt_pkg::RG_LEVEL0_BITS: prdata = mlrt_pkg::DATA_W'(r_level_bits[0]);
            mlrt_pkg::RG_LEVEL1_BITS: prdata = mlrt_pkg::DATA_W'(r_level_bits[1]);
            mlrt_pkg::RG_LEVEL2_BITS: prdata = mlrt_pkg::DATA_W'(r_level_bits[2]);
            mlrt_pkg::RG_LEVEL3_BITS: prdata = mlrt_pkg::DATA_W'(r_level_bits[3]);
            default:                  prdata = '0;
        endcase
    end

    // Validity check and per-level shift amounts.
    always_comb begin
        logic [6:0] sum;
        logic       ok;
        sum = '0;
        ok  = (r_level_count >= 3'd2) && (int'(r_level_count) <= MAX_LEVELS) &&
              (int'(r_level_count) <= mlrt_pkg::HW_LEVELS) &&
              (r_index_bits >= 6'd1) && (int'(r_index_bits) <= INDEX_WIDTH);
        o_cfg.shift = '0;
        for (int l = 0; l < mlrt_pkg::HW_LEVELS; l++) begin
            if (l < int'(r_level_count)) begin
                sum = sum + 7'(r_level_bits[l]);
                if (int'(r_level_bits[l]) > MAX_STRIDE_BITS) begin
                    ok = 1'b0;
                end
                o_cfg.shift[l] = 6'(7'(r_index_bits) - sum);
            end
        end
        if (sum != 7'(r_index_bits)) begin
            ok = 1'b0;
        end
        o_cfg.ok         = ok;
        o_cfg.last       = mlrt_pkg::LVL_W'(r_level_count - 3'd1);
        o_cfg.index_bits = r_index_bits;
        o_cfg.stride     = r_level_bits;
    end

endmodule

/* src/multilevel_radix_index_table.sv */
// Sparse index table held as a radix tree of two to four levels.
// Command channel: an item (i_func, i_key_index, i_new_value) is taken at a clock
// edge where start is high and busy is low. Each item gives one result beat on
// o_old_value, o_found, o_found_index and o_status, shown for one cycle with
// o_done high; the receiver cannot stall it, so nothing waits on the output side.
// Unknown operations, clear, a bad stride configuration and a get, delete
// or next on an empty table answer in the next cycle. get walks the tree one
// level at a time. set does the same, updates the leaf fill count when it
// changes, and allocates each missing child node and a new root (the new node
// is swept to zero through the node memory write port). delete walks the same
// way and updates fill counts while emptied nodes are freed bottom up. next
// reads node entries one at a time and steps back up a level when a node is
// exhausted, starting at the marker's digits, so its time grows with the
// empty entries it passes.
// One item is in work at a time; the node memory port sets the pace.
// Configuration goes through the APB port; any register write empties the table
// and refills the node pool. Reset restores the register defaults and an empty
// table; no clearing pass is needed, since nodes are zeroed when allocated.
module multilevel_radix_index_table #(
    parameter int INDEX_WIDTH     = mlrt_pkg::DEF_INDEX_WIDTH,
    parameter int MAX_STRIDE_BITS = mlrt_pkg::DEF_MAX_STRIDE_BITS,
    parameter int POOL_NODES      = mlrt_pkg::DEF_POOL_NODES,
    parameter int VALUE_WIDTH     = mlrt_pkg::DEF_VALUE_WIDTH,
    parameter int MAX_LEVELS      = mlrt_pkg::DEF_MAX_LEVELS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  i_func,
    input  logic [mlrt_pkg::KEY_W-1:0]  i_key_index,
    input  logic [mlrt_pkg::KEY_W-1:0]  i_new_value,
    output logic                        o_done,
    output logic [mlrt_pkg::KEY_W-1:0]  o_old_value,
    output logic                        o_found,
    output logic [mlrt_pkg::KEY_W-1:0]  o_found_index,
    output logic [1:0]                  o_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mlrt_pkg::APB_AW-1:0] paddr,
    input  logic [mlrt_pkg::DATA_W-1:0] pwdata,
    output logic [mlrt_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    localparam int S          = MAX_STRIDE_BITS;
    localparam int SJ         = S + 1;
    localparam int NODE_W     = $clog2(POOL_NODES);
    localparam int REF_W      = $clog2(POOL_NODES + 1);
    localparam int WORD_W     = (VALUE_WIDTH > REF_W) ? VALUE_WIDTH : REF_W;
    localparam int NAW        = NODE_W + S;
    localparam int NODE_DEPTH = POOL_NODES * (2 ** S);
    localparam int HL         = mlrt_pkg::HW_LEVELS;
    localparam int LW         = mlrt_pkg::LVL_W;
    localparam int KW         = mlrt_pkg::KEY_W;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_WALK_RD   = 14'b00000000000010,
        S_WALK_EV   = 14'b00000000000100,
        S_SET_ROOT  = 14'b00000000001000,
        S_SET_LINK  = 14'b00000000010000,
        S_DEL_CHK   = 14'b00000000100000,
        S_NX_RD     = 14'b00000001000000,
        S_NX_EV     = 14'b00000010000000,
        S_ALLOC_RD  = 14'b00000100000000,
        S_ALLOC_GET = 14'b00001000000000,
        S_ALLOC_CLR = 14'b00010000000000,
        S_FILL_RD   = 14'b00100000000000,
        S_FILL_WR   = 14'b01000000000000,
        S_FIN       = 14'b10000000000000
    } t_state;

    mlrt_pkg::t_cfg cfg;
    logic           cfg_wr;

    // Control state.
    t_state r_state, n_state;
    t_state r_ret, n_ret;
    logic   r_done, n_done;
    logic [REF_W-1:0] r_root, n_root;
    logic [REF_W-1:0] r_fresh, n_fresh;
    logic [REF_W-1:0] r_stk, n_stk;

    // Per-item working registers.
    logic [2:0]              r_op, n_op;
    logic [KW-1:0]           r_idx, n_idx;
    logic [VALUE_WIDTH-1:0]  r_val, n_val;
    logic [LW-1:0]           r_lvl, n_lvl;
    logic [REF_W-1:0]        r_nref, n_nref;
    logic [HL-1:0][REF_W-1:0] r_pref, n_pref;
    logic [HL-1:0][SJ-1:0]   r_j, n_j;
    logic [HL-1:0]           r_tight, n_tight;
    logic [LW-1:0]           r_alloc_lvl, n_alloc_lvl;
    logic                    r_alloc_ok, n_alloc_ok;
    logic                    r_from_stk, n_from_stk;
    logic [NODE_W-1:0]       r_anode, n_anode;
    logic [REF_W-1:0]        r_new, n_new;
    logic [S-1:0]            r_cnt, n_cnt;
    logic [NODE_W-1:0]       r_fnode, n_fnode;
    logic                    r_finc, n_finc;
    logic [SJ-1:0]           r_fill_new, n_fill_new;

    // Result registers.
    logic [KW-1:0] r_old, n_old;
    logic          r_found, n_found;
    logic [KW-1:0] r_fidx, n_fidx;
    logic [1:0]    r_status, n_status;

    // Memory ports.
    logic              nd_we;
    logic [NAW-1:0]    nd_waddr, nd_raddr;
    logic [WORD_W-1:0] nd_wdata, nd_rdata;
    logic              fl_we;
    logic [NODE_W-1:0] fl_waddr;
    logic [SJ-1:0]     fl_wdata, fl_rdata;
    logic              fr_we;
    logic [NODE_W-1:0] fr_waddr, fr_raddr;
    logic [NODE_W-1:0] fr_wdata, fr_rdata;

    // Helpers.
    logic [REF_W:0]   free_cnt;
    logic [LW-1:0]    lvl_up, lvl_dn;
    logic [KW-1:0]    nx_idx;
    logic [KW-1:0]    key_masked;
    logic             leaf;
    logic [REF_W-1:0] dref;

    function automatic logic [S-1:0] smask(input logic [3:0] nb);
        logic [S-1:0] m;
        for (int i = 0; i < S; i++) begin
            m[i] = (i < int'(nb));
        end
        return m;
    endfunction

    function automatic logic [S-1:0] digit(input logic [KW-1:0] x, input logic [5:0] sh,
                                           input logic [3:0] nb);
        logic [KW-1:0] t;
        t = x >> sh;
        return t[S-1:0] & smask(nb);
    endfunction

    function automatic logic [NAW-1:0] slot_addr(input logic [REF_W-1:0] nr,
                                                 input logic [S-1:0] d);
        logic [REF_W-1:0] nn;
        nn = nr - REF_W'(1);
        return {nn[NODE_W-1:0], d};
    endfunction

    mlrt_cfg #(
        .INDEX_WIDTH    (INDEX_WIDTH),
        .MAX_STRIDE_BITS(MAX_STRIDE_BITS),
        .MAX_LEVELS     (MAX_LEVELS)
    ) u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (cfg),
        .o_wr   (cfg_wr)
    );

    // Node entries: values at the leaves, child references inside.
    mlrt_ram #(.WIDTH(WORD_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .i_clk  (i_clk),
        .i_we   (nd_we),
        .i_waddr(nd_waddr),
        .i_wdata(nd_wdata),
        .i_raddr(nd_raddr),
        .o_rdata(nd_rdata)
    );

    // Count of occupied entries per node.
    mlrt_ram #(.WIDTH(SJ), .DEPTH(POOL_NODES)) u_fill_ram (
        .i_clk  (i_clk),
        .i_we   (fl_we),
        .i_waddr(fl_waddr),
        .i_wdata(fl_wdata),
        .i_raddr(r_fnode),
        .o_rdata(fl_rdata)
    );

    // Stack of freed nodes; nodes never handed out come from r_fresh.
    mlrt_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (fr_we),
        .i_waddr(fr_waddr),
        .i_wdata(fr_wdata),
        .i_raddr(fr_raddr),
        .o_rdata(fr_rdata)
    );

    assign free_cnt   = {1'b0, r_fresh} + {1'b0, r_stk};
    assign lvl_up     = r_lvl + LW'(1);
    assign lvl_dn     = r_lvl - LW'(1);
    assign key_masked = i_key_index & mlrt_pkg::low_mask(cfg.index_bits);
    assign leaf       = (r_lvl == cfg.last);
    assign dref       = REF_W'(nd_rdata);

    // Index reached by the next scan at the current leaf entry.
    always_comb begin
        nx_idx = '0;
        for (int l = 0; l < HL; l++) begin
            if (l <= int'(r_lvl)) begin
                nx_idx = nx_idx | (KW'(r_j[l][S-1:0]) << cfg.shift[l]);
            end
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_done      = 1'b0;
        n_root      = r_root;
        n_fresh     = r_fresh;
        n_stk       = r_stk;
        n_op        = r_op;
        n_idx       = r_idx;
        n_val       = r_val;
        n_lvl       = r_lvl;
        n_nref      = r_nref;
        n_pref      = r_pref;
        n_j         = r_j;
        n_tight     = r_tight;
        n_alloc_lvl = r_alloc_lvl;
        n_alloc_ok  = r_alloc_ok;
        n_from_stk  = r_from_stk;
        n_anode     = r_anode;
        n_new       = r_new;
        n_cnt       = r_cnt;
        n_fnode     = r_fnode;
        n_finc      = r_finc;
        n_fill_new  = r_fill_new;
        n_old       = r_old;
        n_found     = r_found;
        n_fidx      = r_fidx;
        n_status    = r_status;
        nd_we       = 1'b0;
        nd_waddr    = slot_addr(r_nref, digit(r_idx, cfg.shift[r_lvl], cfg.stride[r_lvl]));
        nd_wdata    = '0;
        nd_raddr    = slot_addr(r_nref, digit(r_idx, cfg.shift[r_lvl], cfg.stride[r_lvl]));
        fl_we       = 1'b0;
        fl_waddr    = r_fnode;
        fl_wdata    = '0;
        fr_we       = 1'b0;
        fr_waddr    = NODE_W'(r_stk);
        fr_wdata    = '0;
        fr_raddr    = NODE_W'(r_stk - REF_W'(1));

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op     = i_func;
                    n_idx    = key_masked;
                    n_val    = VALUE_WIDTH'(i_new_value);
                    n_old    = '0;
                    n_found  = 1'b0;
                    n_fidx   = '0;
                    n_status = mlrt_pkg::ST_OK;
                    n_lvl    = '0;
                    if (i_func > mlrt_pkg::FN_CLEAR) begin
                        n_done = 1'b1;
                    end else if (!cfg.ok) begin
                        n_status = mlrt_pkg::ST_CFG;
                        n_done   = 1'b1;
                    end else begin
                        case (i_func)
                            mlrt_pkg::FN_CLEAR: begin
                                n_root  = '0;
                                n_fresh = REF_W'(POOL_NODES);
                                n_stk   = '0;
                                n_done  = 1'b1;
                            end
                            mlrt_pkg::FN_SET: begin
                                if (r_root == '0) begin
                                    n_alloc_lvl = '0;
                                    n_ret       = S_SET_ROOT;
                                    n_state     = S_ALLOC_RD;
                                end else begin
                                    n_nref  = r_root;
                                    n_state = S_WALK_RD;
                                end
                            end
                            mlrt_pkg::FN_NEXT: begin
                                if (r_root == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_pref[0]  = r_root;
                                    n_tight[0] = 1'b1;
                                    n_j[0]     = {1'b0, digit(key_masked, cfg.shift[0],
                                                              cfg.stride[0])};
                                    n_state    = S_NX_RD;
                                end
                            end
                            default: begin
                                if (r_root == '0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_nref  = r_root;
                                    n_state = S_WALK_RD;
                                end
                            end
                        endcase
                    end
                end
            end

            // Node read address is driven by default; data arrives next cycle.
            S_WALK_RD: begin
                n_state = S_WALK_EV;
            end

            S_WALK_EV: begin
                case (r_op)
                    mlrt_pkg::FN_SET: begin
                        if (!leaf) begin
                            if (nd_rdata == '0) begin
                                n_alloc_lvl = lvl_up;
                                n_ret       = S_SET_LINK;
                                n_state     = S_ALLOC_RD;
                            end else begin
                                n_nref  = dref;
                                n_lvl   = lvl_up;
                                n_state = S_WALK_RD;
                            end
                        end else begin
                            n_old    = KW'(nd_rdata);
                            nd_we    = 1'b1;
                            nd_wdata = WORD_W'(r_val);
                            n_fnode  = NODE_W'(r_nref - REF_W'(1));
                            n_ret    = S_FIN;
                            if (nd_rdata == '0 && r_val != '0) begin
                                n_finc  = 1'b1;
                                n_state = S_FILL_RD;
                            end else if (nd_rdata != '0 && r_val == '0) begin
                                n_finc  = 1'b0;
                                n_state = S_FILL_RD;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                    end
                    mlrt_pkg::FN_GET: begin
                        if (leaf) begin
                            n_old   = KW'(nd_rdata);
                            n_state = S_FIN;
                        end else if (nd_rdata == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_nref  = dref;
                            n_lvl   = lvl_up;
                            n_state = S_WALK_RD;
                        end
                    end
                    default: begin
                        // Delete: keep the path for the bottom-up release.
                        n_pref[r_lvl] = r_nref;
                        if (leaf) begin
                            n_old = KW'(nd_rdata);
                            if (nd_rdata == '0) begin
                                n_state = S_FIN;
                            end else begin
                                nd_we   = 1'b1;
                                n_fnode = NODE_W'(r_nref - REF_W'(1));
                                n_finc  = 1'b0;
                                n_ret   = S_DEL_CHK;
                                n_state = S_FILL_RD;
                            end
                        end else if (nd_rdata == '0) begin
                            n_state = S_FIN;
                        end else begin
                            n_nref  = dref;
                            n_lvl   = lvl_up;
                            n_state = S_WALK_RD;
                        end
                    end
                endcase
            end

            S_SET_ROOT: begin
                if (!r_alloc_ok) begin
                    n_status = mlrt_pkg::ST_POOL;
                    n_state  = S_FIN;
                end else begin
                    n_root  = r_new;
                    n_nref  = r_new;
                    n_state = S_WALK_RD;
                end
            end

            // Hook the new child into its parent and count it there.
            S_SET_LINK: begin
                if (!r_alloc_ok) begin
                    n_status = mlrt_pkg::ST_POOL;
                    n_state  = S_FIN;
                end else begin
                    nd_we    = 1'b1;
                    nd_wdata = WORD_W'(r_new);
                    n_fnode  = NODE_W'(r_nref - REF_W'(1));
                    n_finc   = 1'b1;
                    n_nref   = r_new;
                    n_lvl    = lvl_up;
                    n_ret    = S_WALK_RD;
                    n_state  = S_FILL_RD;
                end
            end

            // Free an emptied node and clear its entry in the parent.
            S_DEL_CHK: begin
                if (r_fill_new == '0) begin
                    if (free_cnt < (REF_W + 1)'(POOL_NODES)) begin
                        fr_we    = 1'b1;
                        fr_wdata = NODE_W'(r_pref[r_lvl] - REF_W'(1));
                        n_stk    = r_stk + REF_W'(1);
                    end
                    if (r_lvl == '0) begin
                        n_root  = '0;
                        n_state = S_FIN;
                    end else begin
                        nd_we    = 1'b1;
                        nd_waddr = slot_addr(r_pref[lvl_dn],
                                             digit(r_idx, cfg.shift[lvl_dn], cfg.stride[lvl_dn]));
                        n_fnode  = NODE_W'(r_pref[lvl_dn] - REF_W'(1));
                        n_finc   = 1'b0;
                        n_lvl    = lvl_dn;
                        n_ret    = S_DEL_CHK;
                        n_state  = S_FILL_RD;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end

            // Depth-first scan for the first occupied index at or above the marker.
            S_NX_RD: begin
                if (r_j[r_lvl] > {1'b0, smask(cfg.stride[r_lvl])}) begin
                    if (r_lvl == '0) begin
                        n_state = S_FIN;
                    end else begin
                        n_j[lvl_dn] = r_j[lvl_dn] + SJ'(1);
                        n_lvl       = lvl_dn;
                    end
                end else begin
                    nd_raddr = slot_addr(r_pref[r_lvl], r_j[r_lvl][S-1:0]);
                    n_state  = S_NX_EV;
                end
            end

            S_NX_EV: begin
                if (nd_rdata == '0) begin
                    n_j[r_lvl] = r_j[r_lvl] + SJ'(1);
                    n_state    = S_NX_RD;
                end else if (leaf) begin
                    if (nx_idx >= r_idx) begin
                        n_found = 1'b1;
                        n_old   = KW'(nd_rdata);
                        n_fidx  = nx_idx;
                        n_state = S_FIN;
                    end else begin
                        n_j[r_lvl] = r_j[r_lvl] + SJ'(1);
                        n_state    = S_NX_RD;
                    end
                end else begin
                    n_pref[lvl_up]  = dref;
                    n_tight[lvl_up] = r_tight[r_lvl] &&
                        (r_j[r_lvl][S-1:0] ==
                         digit(r_idx, cfg.shift[r_lvl], cfg.stride[r_lvl]));
                    if (n_tight[lvl_up]) begin
                        n_j[lvl_up] = {1'b0, digit(r_idx, cfg.shift[lvl_up],
                                                   cfg.stride[lvl_up])};
                    end else begin
                        n_j[lvl_up] = '0;
                    end
                    n_lvl   = lvl_up;
                    n_state = S_NX_RD;
                end
            end

            // Node allocation: recycled stack first, then never-used nodes.
            S_ALLOC_RD: begin
                if (r_fresh == '0 && r_stk == '0) begin
                    n_alloc_ok = 1'b0;
                    n_state    = r_ret;
                end else if (r_stk != '0) begin
                    n_stk      = r_stk - REF_W'(1);
                    n_from_stk = 1'b1;
                    n_state    = S_ALLOC_GET;
                end else begin
                    n_anode    = NODE_W'(REF_W'(POOL_NODES) - r_fresh);
                    n_fresh    = r_fresh - REF_W'(1);
                    n_from_stk = 1'b0;
                    n_state    = S_ALLOC_GET;
                end
            end

            S_ALLOC_GET: begin
                n_anode  = r_from_stk ? fr_rdata : r_anode;
                fl_we    = 1'b1;
                fl_waddr = n_anode;
                n_cnt    = '0;
                n_state  = S_ALLOC_CLR;
            end

            // Zero the entries that the node's level uses.
            S_ALLOC_CLR: begin
                nd_we    = 1'b1;
                nd_waddr = {r_anode, r_cnt};
                if (r_cnt == smask(cfg.stride[r_alloc_lvl])) begin
                    n_alloc_ok = 1'b1;
                    n_new      = REF_W'(r_anode) + REF_W'(1);
                    n_state    = r_ret;
                end else begin
                    n_cnt = r_cnt + S'(1);
                end
            end

            // Fill count read-modify-write.
            S_FILL_RD: begin
                n_state = S_FILL_WR;
            end

            S_FILL_WR: begin
                fl_we      = 1'b1;
                fl_wdata   = r_finc ? (fl_rdata + SJ'(1)) : (fl_rdata - SJ'(1));
                n_fill_new = fl_wdata;
                n_state    = r_ret;
            end

            S_FIN: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A register write empties the table.
        if (cfg_wr) begin
            n_root  = '0;
            n_fresh = REF_W'(POOL_NODES);
            n_stk   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_done  <= 1'b0;
            r_root  <= '0;
            r_fresh <= REF_W'(POOL_NODES);
            r_stk   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_done  <= n_done;
            r_root  <= n_root;
            r_fresh <= n_fresh;
            r_stk   <= n_stk;
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_idx       <= n_idx;
        r_val       <= n_val;
        r_lvl       <= n_lvl;
        r_nref      <= n_nref;
        r_pref      <= n_pref;
        r_j         <= n_j;
        r_tight     <= n_tight;
        r_alloc_lvl <= n_alloc_lvl;
        r_alloc_ok  <= n_alloc_ok;
        r_from_stk  <= n_from_stk;
        r_anode     <= n_anode;
        r_new       <= n_new;
        r_cnt       <= n_cnt;
        r_fnode     <= n_fnode;
        r_finc      <= n_finc;
        r_fill_new  <= n_fill_new;
        r_old       <= n_old;
        r_found     <= n_found;
        r_fidx      <= n_fidx;
        r_status    <= n_status;
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_old_value   = r_old;
    assign o_found       = r_found;
    assign o_found_index = r_fidx;
    assign o_status      = r_status;

`ifndef SYNTHESIS
    // The pool never holds more free nodes than it has.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        free_cnt <= (REF_W + 1)'(POOL_NODES))
        else $error("free node count exceeds pool size");

    // The root reference always names a pool node or none.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_root <= REF_W'(POOL_NODES))
        else $error("root reference out of range");

    // Unknown operations answer in the next cycle with status ok.
    a_unknown_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func > mlrt_pkg::FN_CLEAR) |=>
        (o_done && o_status == mlrt_pkg::ST_OK))
        else $error("unknown operation not answered at once");

    // A result beat carries a defined status.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status == mlrt_pkg::ST_OK || o_status == mlrt_pkg::ST_POOL ||
                    o_status == mlrt_pkg::ST_CFG))
        else $error("undefined status code");
`endif

endmodule

/* tb/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES     = 64;
    localparam int SLOTS     = 256;
    localparam int CYC_LIMIT = 150000000;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] key;
        logic [31:0] val;
    } t_op;

    typedef struct {
        logic [31:0] oldv;
        logic        found;
        logic [31:0] fidx;
        logic [1:0]  st;
    } t_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_func = '0;
    logic [31:0] i_key_index = '0;
    logic [31:0] i_new_value = '0;
    logic        o_done;
    logic [31:0] o_old_value;
    logic        o_found;
    logic [31:0] o_found_index;
    logic [1:0]  o_status;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [mlrt_pkg::APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    multilevel_radix_index_table dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copy of the table: configuration, node pool and node memory.
    logic [31:0] nstore [NODES*SLOTS];
    int          root_ref;
    int          free_list [NODES];
    int          free_cnt;
    int          fill_cnt [NODES];
    int          cfg_ib, cfg_lc;
    int          cfg_lb [4];
    bit          cfg_ok;
    int          lvl_shift [4];
    longint unsigned lvl_mask [4];

    t_op  pending_ops [$];
    t_res expected_res [$];
    int   accepted_cnt = 0;
    int   driven_cnt = 0;
    int   gap = 0;
    int   mismatches = 0;
    int   cycles = 0;
    logic [31:0] key_pool [16];

    function automatic void pool_refill();
        for (int i = 0; i < NODES; i++) begin
            free_list[i] = NODES - 1 - i;
            fill_cnt[i] = 0;
        end
        free_cnt = NODES;
        root_ref = 0;
    endfunction

    function automatic void decode_cfg();
        int sum;
        sum = 0;
        cfg_ok = cfg_lc >= 2 && cfg_lc <= 4 && cfg_ib >= 1 && cfg_ib <= 32;
        for (int i = 0; i < 4; i++) begin
            lvl_shift[i] = 0;
            lvl_mask[i] = 0;
        end
        if (cfg_ok) begin
            for (int i = 0; i < cfg_lc; i++) begin
                if (cfg_lb[i] > 8) cfg_ok = 0;
                sum += cfg_lb[i];
            end
            if (sum != cfg_ib) cfg_ok = 0;
        end
        if (cfg_ok) begin
            sum = 0;
            for (int i = 0; i < cfg_lc; i++) begin
                sum += cfg_lb[i];
                lvl_shift[i] = cfg_ib - sum;
                lvl_mask[i] = (64'd1 << cfg_lb[i]) - 1;
            end
        end
    endfunction

    function automatic void table_write_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            mlrt_pkg::RG_INDEX_BITS:  cfg_ib = value[5:0];
            mlrt_pkg::RG_LEVEL_COUNT: cfg_lc = value[2:0];
            mlrt_pkg::RG_LEVEL0_BITS: cfg_lb[0] = value[3:0];
            mlrt_pkg::RG_LEVEL1_BITS: cfg_lb[1] = value[3:0];
            mlrt_pkg::RG_LEVEL2_BITS: cfg_lb[2] = value[3:0];
            mlrt_pkg::RG_LEVEL3_BITS: cfg_lb[3] = value[3:0];
            default: return;
        endcase
        decode_cfg();
        pool_refill();
    endfunction

    function automatic int node_take();
        int n;
        if (free_cnt == 0) return 0;
        free_cnt--;
        n = free_list[free_cnt];
        for (int j = 0; j < SLOTS; j++) nstore[n*SLOTS + j] = '0;
        fill_cnt[n] = 0;
        return n + 1;
    endfunction

    function automatic int slot_at(int r, int lvl, longint unsigned idx);
        return (r - 1) * SLOTS + int'((idx >> lvl_shift[lvl]) & lvl_mask[lvl]);
    endfunction

    // Depth-first search for the first occupied leaf at or above the marker.
    function automatic bit scan_next(int r, int lvl, longint unsigned prefix,
                                     longint unsigned marker,
                                     output longint unsigned fi, output logic [31:0] fv);
        logic [31:0]     e;
        longint unsigned idx;
        for (longint unsigned j = 0; j <= lvl_mask[lvl]; j++) begin
            e = nstore[(r - 1) * SLOTS + int'(j)];
            idx = prefix | (j << lvl_shift[lvl]);
            if (e == 0) continue;
            if (lvl == cfg_lc - 1) begin
                if (idx >= marker) begin
                    fi = idx;
                    fv = e;
                    return 1;
                end
            end else if (scan_next(int'(e), lvl + 1, idx, marker, fi, fv)) begin
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic t_res table_apply(logic [2:0] func, logic [31:0] key,
                                         logic [31:0] value);
        t_res            r;
        longint unsigned idx, fi;
        logic [31:0]     fv;
        int              cur, lvl, s, c;
        int              pref [4];
        int              pslot [4];
        bit              ok;
        r = '{default: '0};
        if (func > mlrt_pkg::FN_CLEAR) return r;
        if (!cfg_ok) begin
            r.st = mlrt_pkg::ST_CFG;
            return r;
        end
        idx = longint'(key) & ((64'd1 << cfg_ib) - 1);
        case (func)
            mlrt_pkg::FN_SET: begin
                if (root_ref == 0) root_ref = node_take();
                cur = root_ref;
                for (lvl = 0; cur != 0 && lvl + 1 < cfg_lc; lvl++) begin
                    s = slot_at(cur, lvl, idx);
                    if (nstore[s] == 0) begin
                        c = node_take();
                        if (c == 0) begin
                            cur = 0;
                            break;
                        end
                        nstore[s] = c;
                        fill_cnt[cur-1]++;
                    end
                    cur = int'(nstore[s]);
                end
                if (cur == 0) begin
                    r.st = mlrt_pkg::ST_POOL;
                end else begin
                    s = slot_at(cur, cfg_lc - 1, idx);
                    r.oldv = nstore[s];
                    nstore[s] = value;
                    if (r.oldv == 0 && value != 0) fill_cnt[cur-1]++;
                    else if (r.oldv != 0 && value == 0) fill_cnt[cur-1]--;
                end
            end
            mlrt_pkg::FN_GET: begin
                cur = root_ref;
                for (lvl = 0; cur != 0 && lvl < cfg_lc; lvl++) begin
                    s = slot_at(cur, lvl, idx);
                    if (lvl + 1 == cfg_lc) r.oldv = nstore[s];
                    else cur = int'(nstore[s]);
                end
            end
            mlrt_pkg::FN_DEL: begin
                ok = 1;
                cur = root_ref;
                for (lvl = 0; lvl < cfg_lc; lvl++) begin
                    if (cur == 0) begin
                        ok = 0;
                        break;
                    end
                    pref[lvl] = cur;
                    pslot[lvl] = slot_at(cur, lvl, idx);
                    if (lvl + 1 < cfg_lc) cur = int'(nstore[pslot[lvl]]);
                end
                if (ok) begin
                    lvl = cfg_lc - 1;
                    r.oldv = nstore[pslot[lvl]];
                    if (r.oldv != 0) begin
                        // Free emptied nodes from the leaf upward.
                        nstore[pslot[lvl]] = 0;
                        fill_cnt[pref[lvl]-1]--;
                        while (fill_cnt[pref[lvl]-1] == 0) begin
                            if (free_cnt < NODES) begin
                                free_list[free_cnt] = pref[lvl] - 1;
                                free_cnt++;
                            end
                            if (lvl == 0) begin
                                root_ref = 0;
                                break;
                            end
                            lvl--;
                            nstore[pslot[lvl]] = 0;
                            fill_cnt[pref[lvl]-1]--;
                        end
                    end
                end
            end
            mlrt_pkg::FN_NEXT: begin
                if (root_ref != 0 && scan_next(root_ref, 0, 0, idx, fi, fv)) begin
                    r.found = 1'b1;
                    r.oldv = fv;
                    r.fidx = fi[31:0];
                end
            end
            default: pool_refill();
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Command driver: presents queued beats with random gaps.
    always @(negedge i_clk) begin
        bit hold;
        hold = start && (accepted_cnt == driven_cnt);
        if (start && !hold) begin
            driven_cnt++;
            void'(pending_ops.pop_front());
            gap = pick_gap();
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (hold) begin
            start <= 1'b1;
        end else if (gap > 0) begin
            gap--;
            start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
            start <= 1'b1;
            i_func <= pending_ops[0].func;
            i_key_index <= pending_ops[0].key;
            i_new_value <= pending_ops[0].val;
        end else begin
            start <= 1'b0;
        end
    end

    // Result monitor: checks each result beat, then predicts for an accepted command.
    always @(posedge i_clk) begin
        t_res want;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: old %h found %b idx %h st %0d",
                                 o_old_value, o_found, o_found_index, o_status);
                end else begin
                    want = expected_res.pop_front();
                    if (o_old_value !== want.oldv || o_found !== want.found ||
                        o_found_index !== want.fidx || o_status !== want.st) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp old %h found %b idx %h st %0d, ",
                                      "got old %h found %b idx %h st %0d"},
                                     want.oldv, want.found, want.fidx, want.st,
                                     o_old_value, o_found, o_found_index, o_status);
                    end
                end
            end
            if (start && !busy) begin
                expected_res.push_back(table_apply(i_func, i_key_index, i_new_value));
                accepted_cnt <= accepted_cnt + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYC_LIMIT) begin
            $display("multilevel_radix_index_table verification failed");
            $finish;
        end
    end

    task automatic push_op(logic [2:0] func, logic [31:0] key, logic [31:0] value);
        t_op o;
        o.func = func;
        o.key = key;
        o.val = value;
        pending_ops.push_back(o);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= mlrt_pkg::APB_AW'({idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        table_write_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic load_cfg(int ib, int lc, int l0, int l1, int l2, int l3);
        reg_write(mlrt_pkg::RG_INDEX_BITS, ib);
        reg_write(mlrt_pkg::RG_LEVEL_COUNT, lc);
        reg_write(mlrt_pkg::RG_LEVEL0_BITS, l0);
        reg_write(mlrt_pkg::RG_LEVEL1_BITS, l1);
        reg_write(mlrt_pkg::RG_LEVEL2_BITS, l2);
        reg_write(mlrt_pkg::RG_LEVEL3_BITS, l3);
    endtask

    // Wait until every command is taken and answered, then let the block settle.
    task automatic drain();
        @(posedge i_clk);
        while (pending_ops.size() != 0 || expected_res.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Random commands, mostly on keys already in use so that hits, frees and
    // pool exhaustion all occur; ignored bits above the index are randomized.
    task automatic push_random(int count);
        int          n, r, k;
        logic [31:0] imask, key, value;
        logic [2:0]  func;
        n = 0;
        imask = (cfg_ib >= 32) ? 32'hFFFF_FFFF : ((32'd1 << cfg_ib) - 1);
        for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
        while (n < count) begin
            r = $urandom_range(99);
            if (r < 36) func = mlrt_pkg::FN_SET;
            else if (r < 56) func = mlrt_pkg::FN_GET;
            else if (r < 76) func = mlrt_pkg::FN_DEL;
            else if (r < 93) func = mlrt_pkg::FN_NEXT;
            else if (r < 95) func = mlrt_pkg::FN_CLEAR;
            else func = 3'($urandom_range(5, 7));
            k = $urandom_range(15);
            if ($urandom_range(3) != 0) key = (key_pool[k] & imask) | ($urandom & ~imask);
            else key = $urandom;
            if (func == mlrt_pkg::FN_SET && $urandom_range(3) == 0) key_pool[k] = key;
            r = $urandom_range(19);
            value = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            push_op(func, key, value);
            if (func <= mlrt_pkg::FN_CLEAR) n++;
        end
    endtask

    initial begin
        cfg_ib = mlrt_pkg::RST_INDEX_BITS;
        cfg_lc = mlrt_pkg::RST_LEVEL_COUNT;
        for (int i = 0; i < 4; i++) cfg_lb[i] = mlrt_pkg::RST_LEVEL_BITS[i];
        decode_cfg();
        pool_refill();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, extremes of key and value, zero stores,
        // ignored key bits, unknown operations and clear.
        push_op(mlrt_pkg::FN_GET, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_NEXT, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_DEL, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_SET, 32'h0, 32'hFFFF_FFFF);
        push_op(mlrt_pkg::FN_SET, 32'hFFFF_FFFF, 32'h1);
        push_op(mlrt_pkg::FN_GET, 32'h00FF_FFFF, 32'h0);
        push_op(mlrt_pkg::FN_NEXT, 32'h1, 32'h0);
        push_op(mlrt_pkg::FN_NEXT, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_SET, 32'h5, 32'h0);
        push_op(mlrt_pkg::FN_DEL, 32'h5, 32'h0);
        push_op(mlrt_pkg::FN_SET, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_DEL, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_NEXT, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_DEL, 32'hFF00_FFFF, 32'h0);
        push_op(mlrt_pkg::FN_GET, 32'hFFFF_FFFF, 32'h0);
        push_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(3'd6, 32'h1234, 32'h5678);
        push_op(3'd7, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_SET, 32'h0012_3456, 32'hA5A5_A5A5);
        push_op(mlrt_pkg::FN_CLEAR, 32'h0, 32'h0);
        push_op(mlrt_pkg::FN_GET, 32'h0012_3456, 32'h0);
        push_random(150);
        drain();

        load_cfg(4, 2, 2, 2, 0, 0);
        push_random(150);
        drain();
        load_cfg(32, 4, 8, 8, 8, 8);
        push_random(200);
        drain();
        load_cfg(1, 2, 1, 0, 0, 0);
        push_random(80);
        drain();
        load_cfg(63, 7, 15, 15, 15, 15);
        push_random(30);
        drain();
        load_cfg(8, 1, 8, 0, 0, 0);
        push_random(30);
        drain();
        load_cfg(18, 2, 9, 9, 0, 0);
        push_random(30);
        drain();
        load_cfg(12, 3, 4, 4, 4, 0);
        push_random(200);
        drain();
        load_cfg(24, 3, 8, 8, 8, 0);
        push_random(150);
        drain();

        if (mismatches == 0) begin
            $display("multilevel_radix_index_table verification clean");
        end else begin
            $display("multilevel_radix_index_table verification failed");
        end
        $finish;
    end

endmodule
